// ===== hw/rtl/amou_pkg.sv =====
// shared types and constants of the atomic memory operation unit
`timescale 1ns / 1ps

package amou_pkg;

  // store geometry: words of 64 bits, kept as an even and an odd bank
  localparam int STORE_WORDS = 1024;
  localparam int ROWS        = STORE_WORDS / 2;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DATA_W      = 64;

  // operation codes; code 7 behaves as a read
  typedef enum logic [2:0] {
    K_FETCH_ADD     = 3'd0,
    K_SWAP          = 3'd1,
    K_COMPARE_STORE = 3'd2,
    K_READ          = 3'd3,
    K_FETCH_AND     = 3'd4,
    K_FETCH_OR      = 3'd5,
    K_FETCH_XOR     = 3'd6
  } kind_t;

  // access width codes; code 3 behaves as 128-bit
  localparam logic [1:0] W_32  = 2'd0;
  localparam logic [1:0] W_64  = 2'd1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // decoded request held while the store is read
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  width_select;
    logic        bank;
    logic        half;
  } req_t;

  // write enables for the two banks
  typedef struct packed {
    logic we_even;
    logic we_odd;
  } bank_we_t;

endpackage

// ===== hw/rtl/amou_ram.sv =====
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps

module amou_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/amou_alu.sv =====
// modify step: new store contents and previous value from the words read
`timescale 1ns / 1ps

module amou_alu import amou_pkg::*; (
  input  req_t               req,
  input  logic [63:0]        operand_a_low,
  input  logic [63:0]        operand_a_high,
  input  logic [63:0]        operand_b_low,
  input  logic [63:0]        operand_b_high,
  input  logic [DATA_W-1:0]  old_even,
  input  logic [DATA_W-1:0]  old_odd,
  output logic [DATA_W-1:0]  new_even,
  output logic [DATA_W-1:0]  new_odd,
  output bank_we_t           bank_we,
  output logic [63:0]        previous_low,
  output logic [63:0]        previous_high
);

  logic [DATA_W-1:0] old_word;
  logic [31:0]       old_half;
  logic [127:0]      old_v;
  logic [127:0]      a_v;
  logic [127:0]      b_v;
  logic [127:0]      res_v;
  logic [DATA_W-1:0] narrow_word;

  // operation on zero-extended operands; truncation gives the width wrap
  function automatic logic [127:0] apply_op(kind_t k, logic [127:0] o,
                                           logic [127:0] a, logic [127:0] b);
    logic [127:0] r;
    case (k)
      K_FETCH_ADD:     r = o + a;
      K_SWAP:          r = a;
      K_COMPARE_STORE: r = (o == a) ? b : o;
      K_FETCH_AND:     r = o & a;
      K_FETCH_OR:      r = o | a;
      K_FETCH_XOR:     r = o ^ a;
      default:         r = o;
    endcase
    return r;
  endfunction

  // operand alignment per access width
  always_comb begin
    old_word = req.bank ? old_odd : old_even;
    old_half = req.half ? old_word[63:32] : old_word[31:0];
    case (req.width_select)
      W_32: begin
        old_v = {96'd0, old_half};
        a_v   = {96'd0, operand_a_low[31:0]};
        b_v   = {96'd0, operand_b_low[31:0]};
      end
      W_64: begin
        old_v = {64'd0, old_word};
        a_v   = {64'd0, operand_a_low};
        b_v   = {64'd0, operand_b_low};
      end
      default: begin
        old_v = {old_odd, old_even};
        a_v   = {operand_a_high, operand_a_low};
        b_v   = {operand_b_high, operand_b_low};
      end
    endcase
    res_v = apply_op(req.kind, old_v, a_v, b_v);
  end

  // merge back into the banks
  always_comb begin
    narrow_word = old_word;
    case (req.width_select)
      W_32: begin
        if (req.half) begin
          narrow_word[63:32] = res_v[31:0];
        end else begin
          narrow_word[31:0] = res_v[31:0];
        end
      end
      W_64: narrow_word = res_v[63:0];
      default: narrow_word = old_word;
    endcase

    if (req.width_select == W_32 || req.width_select == W_64) begin
      new_even        = narrow_word;
      new_odd         = narrow_word;
      bank_we.we_even = !req.bank;
      bank_we.we_odd  = req.bank;
    end else begin
      new_even        = res_v[63:0];
      new_odd         = res_v[127:64];
      bank_we.we_even = 1'b1;
      bank_we.we_odd  = 1'b1;
    end
  end

  assign previous_low  = old_v[63:0];
  assign previous_high = old_v[127:64];

endmodule

// ===== hw/rtl/atomic_memory_op_unit.sv =====
// top level of the atomic memory operation unit
`timescale 1ns / 1ps

// Memory-side atomic unit over a store of 1024 words of 64 bits, kept as
// an even-word bank and an odd-word bank so a 128-bit pair is one row.
// Input channel: in_valid / in_stall with kind, width_select, word_address
// and the a and b operands; one beat is one request.
// Output channel: out_valid / out_stall with previous_low / previous_high;
// one beat per request, in request order.
// The row is read at the accepting edge, modified in the following cycle
// and written back, together with loading the result register, at the
// first edge with the result slot free, when the result beat is offered.
// No request is taken until the write back, so with the registered bank
// read no forwarding is needed. The result sits in an output register;
// the next request is accepted while it waits. If the receiver stalls,
// the following request holds in the modify stage and in_stall stays
// high until the result slot frees. After reset a clearing pass writes zero
// to all 512 rows, one row per cycle, with in_stall high throughout it.

module atomic_memory_op_unit import amou_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [1:0]  width_select,
  input  logic [10:0] word_address,
  input  logic [63:0] operand_a_low,
  input  logic [63:0] operand_a_high,
  input  logic [63:0] operand_b_low,
  input  logic [63:0] operand_b_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] previous_low,
  output logic [63:0] previous_high
);

  state_t            state;
  state_t            state_next;
  logic [ROW_W-1:0]  clr_row;
  logic [ROW_W-1:0]  clr_row_next;
  logic              in_accept;
  logic              fire;
  logic              out_valid_next;

  req_t              req;
  logic [ROW_W-1:0]  req_row;
  logic [63:0]       a_lo;
  logic [63:0]       a_hi;
  logic [63:0]       b_lo;
  logic [63:0]       b_hi;

  logic [DATA_W-1:0] old_even;
  logic [DATA_W-1:0] old_odd;
  logic [DATA_W-1:0] new_even;
  logic [DATA_W-1:0] new_odd;
  bank_we_t          bank_we;
  logic [63:0]       prev_lo;
  logic [63:0]       prev_hi;

  logic              we_even;
  logic              we_odd;
  logic [ROW_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata_even;
  logic [DATA_W-1:0] wdata_odd;
  logic [ROW_W-1:0]  raddr;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign raddr     = ROW_W'(word_address >> 2);

  // sequencer state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_row   <= clr_row_next;
      out_valid <= out_valid_next;
    end
  end

  // next state, write back and result slot control
  always_comb begin
    state_next     = state;
    clr_row_next   = clr_row;
    fire           = 1'b0;
    case (state)
      ST_CLEAR: begin
        clr_row_next = clr_row + 1'b1;
        if (clr_row == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid || !out_stall) begin
          fire       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
    out_valid_next = fire || (out_valid && out_stall);
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req.kind         <= kind_t'(kind);
      req.width_select <= width_select;
      req.bank         <= word_address[1];
      req.half         <= word_address[0];
      req_row          <= raddr;
      a_lo             <= operand_a_low;
      a_hi             <= operand_a_high;
      b_lo             <= operand_b_low;
      b_hi             <= operand_b_high;
    end
  end

  // bank write mux: clearing pass or write back
  always_comb begin
    if (state == ST_CLEAR) begin
      we_even    = 1'b1;
      we_odd     = 1'b1;
      waddr      = clr_row;
      wdata_even = '0;
      wdata_odd  = '0;
    end else begin
      we_even    = fire && bank_we.we_even;
      we_odd     = fire && bank_we.we_odd;
      waddr      = req_row;
      wdata_even = new_even;
      wdata_odd  = new_odd;
    end
  end

  amou_ram #(.DEPTH(ROWS), .WIDTH(DATA_W)) u_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata (wdata_even),
    .re    (in_accept),
    .raddr (raddr),
    .rdata (old_even)
  );

  amou_ram #(.DEPTH(ROWS), .WIDTH(DATA_W)) u_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata (wdata_odd),
    .re    (in_accept),
    .raddr (raddr),
    .rdata (old_odd)
  );

  amou_alu u_alu (
    .req            (req),
    .operand_a_low  (a_lo),
    .operand_a_high (a_hi),
    .operand_b_low  (b_lo),
    .operand_b_high (b_hi),
    .old_even       (old_even),
    .old_odd        (old_odd),
    .new_even       (new_even),
    .new_odd        (new_odd),
    .bank_we        (bank_we),
    .previous_low   (prev_lo),
    .previous_high  (prev_hi)
  );

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      previous_low  <= prev_lo;
      previous_high <= prev_hi;
    end
  end

endmodule

// ===== hw/rtl/amou_checker.sv =====
// port-level checks of the atomic memory operation unit and their binding
`timescale 1ns / 1ps

module amou_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] previous_low,
  input logic [63:0] previous_high
);

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // no result pending after reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while busy");

  // a new result only comes from a request in progress
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(previous_low) && $stable(previous_high)))
    else $error("stalled result changed");

endmodule

bind atomic_memory_op_unit amou_port_checker u_amou_port_checker (.*);

// ===== tb/sv/amou_checker.sv =====
// checker for the atomic memory operation unit: predicts previous values and compares beats
`timescale 1ns / 1ps

module amou_checker import amou_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [1:0]  width_select,
  input  logic [10:0] word_address,
  input  logic [63:0] operand_a_low,
  input  logic [63:0] operand_a_high,
  input  logic [63:0] operand_b_low,
  input  logic [63:0] operand_b_high,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] previous_low,
  input  logic [63:0] previous_high,
  output int          mismatch_count,
  output int          pending_results
);

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } prev_value_t;

  // private copy of the word store and the previous values still to come
  logic [DATA_W-1:0] shadow_words [STORE_WORDS];
  prev_value_t       prev_value_q [$];
  int                errors = 0;

  // one read-modify-write on a single lane
  function automatic logic [63:0] modify_lane(input kind_t op, input logic [63:0] old,
                                              input logic [63:0] a, input logic [63:0] b,
                                              input logic equal);
    case (op)
      K_FETCH_ADD:     return old + a;
      K_SWAP:          return a;
      K_COMPARE_STORE: return equal ? b : old;
      K_FETCH_AND:     return old & a;
      K_FETCH_OR:      return old | a;
      K_FETCH_XOR:     return old ^ a;
      default:         return old;
    endcase
  endfunction

  // apply one request to the shadow store and return the old value
  task automatic apply_request(input logic [2:0] op_code, input logic [1:0] wsel,
                               input logic [10:0] addr,
                               input logic [63:0] a_lo, input logic [63:0] a_hi,
                               input logic [63:0] b_lo, input logic [63:0] b_hi,
                               output prev_value_t prev);
    kind_t        op;
    logic [9:0]   idx_lo;
    logic [9:0]   idx_hi;
    logic [31:0]  old32;
    logic [63:0]  lane;
    logic [63:0]  old_lo;
    logic [63:0]  old_hi;
    logic [127:0] sum;
    logic         equal;
    op     = kind_t'(op_code);
    idx_lo = addr[10:1];
    case (wsel)
      W_32: begin
        // odd address picks the upper half of the word
        old32 = addr[0] ? shadow_words[idx_lo][63:32] : shadow_words[idx_lo][31:0];
        lane  = modify_lane(op, {32'd0, old32}, {32'd0, a_lo[31:0]}, {32'd0, b_lo[31:0]},
                            old32 == a_lo[31:0]);
        if (addr[0]) begin
          shadow_words[idx_lo][63:32] = lane[31:0];
        end else begin
          shadow_words[idx_lo][31:0] = lane[31:0];
        end
        prev = {64'd0, 32'd0, old32};
      end
      W_64: begin
        old_lo = shadow_words[idx_lo];
        shadow_words[idx_lo] = modify_lane(op, old_lo, a_lo, b_lo, old_lo == a_lo);
        prev = {64'd0, old_lo};
      end
      default: begin
        // 128-bit pair, low half in the even word; width code 3 lands here too
        idx_lo = {addr[10:2], 1'b0};
        idx_hi = {addr[10:2], 1'b1};
        old_lo = shadow_words[idx_lo];
        old_hi = shadow_words[idx_hi];
        equal  = (old_lo == a_lo) && (old_hi == a_hi);
        if (op == K_FETCH_ADD) begin
          sum = {old_hi, old_lo} + {a_hi, a_lo};
          shadow_words[idx_lo] = sum[63:0];
          shadow_words[idx_hi] = sum[127:64];
        end else begin
          shadow_words[idx_lo] = modify_lane(op, old_lo, a_lo, b_lo, equal);
          shadow_words[idx_hi] = modify_lane(op, old_hi, a_hi, b_hi, equal);
        end
        prev = {old_hi, old_lo};
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    prev_value_t predicted;
    prev_value_t expected;
    if (rst) begin
      for (int i = 0; i < STORE_WORDS; i++) shadow_words[i] = '0;
      prev_value_q.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (prev_value_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result beat with nothing expected: low=%h high=%h",
                     previous_low, previous_high);
        end else begin
          expected = prev_value_q.pop_front();
          if (previous_low !== expected.low) begin
            errors++;
            if (errors <= 10)
              $display("previous_low mismatch: expected %h, got %h",
                       expected.low, previous_low);
          end
          if (previous_high !== expected.high) begin
            errors++;
            if (errors <= 10)
              $display("previous_high mismatch: expected %h, got %h",
                       expected.high, previous_high);
          end
        end
      end
      // request beat into the predictor
      if (in_valid && !in_stall) begin
        apply_request(kind, width_select, word_address, operand_a_low, operand_a_high,
                      operand_b_low, operand_b_high, predicted);
        prev_value_q.push_back(predicted);
      end
    end
    mismatch_count  <= errors;
    pending_results <= prev_value_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the atomic memory operation unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top import amou_pkg::*; ();

  localparam logic [1:0]  W_128          = 2'd2;
  localparam logic [1:0]  W_128_ALIAS    = 2'd3;
  localparam logic [2:0]  K_UNDEFINED    = 3'd7;
  localparam logic [63:0] ONES           = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          RANDOM_ITEMS   = 1800;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          HOLD_AT_RESULT = 1500;
  localparam int          DRAIN_CYCLES   = 8;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic [2:0]  kind           = '0;
  logic [1:0]  width_select   = '0;
  logic [10:0] word_address   = '0;
  logic [63:0] operand_a_low  = '0;
  logic [63:0] operand_a_high = '0;
  logic [63:0] operand_b_low  = '0;
  logic [63:0] operand_b_high = '0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] previous_low;
  logic [63:0] previous_high;
  int          mismatch_count;
  int          pending_results;

  int send_idle_pct = 26;
  int recv_idle_pct = 70;
  int idle_cycles   = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // shared operand pairs so swaps and compares meet on the same values
  logic [63:0] pool_low  [4] = '{64'h0, 64'h0123_4567_89AB_CDEF, ONES, 64'h8000_0000_FFFF_FFFF};
  logic [63:0] pool_high [4] = '{64'h0, 64'hFEDC_BA98_7654_3210, ONES, 64'h0000_0001_0000_0000};

  atomic_memory_op_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .width_select   (width_select),
    .word_address   (word_address),
    .operand_a_low  (operand_a_low),
    .operand_a_high (operand_a_high),
    .operand_b_low  (operand_b_low),
    .operand_b_high (operand_b_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .previous_low   (previous_low),
    .previous_high  (previous_high)
  );

  amou_checker checker_inst (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .width_select    (width_select),
    .word_address    (word_address),
    .operand_a_low   (operand_a_low),
    .operand_a_high  (operand_a_high),
    .operand_b_low   (operand_b_low),
    .operand_b_high  (operand_b_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .previous_low    (previous_low),
    .previous_high   (previous_high),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off so the unit backs up
  always @(posedge clk) begin
    if (out_valid && !out_stall) results_seen <= results_seen + 1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[atomic_memory_op_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one request beat, with random gaps first, and wait for acceptance
  task automatic send_request(input logic [2:0] op, input logic [1:0] wsel,
                              input logic [10:0] addr,
                              input logic [63:0] a_lo, input logic [63:0] a_hi,
                              input logic [63:0] b_lo, input logic [63:0] b_hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= op;
    width_select   <= wsel;
    word_address   <= addr;
    operand_a_low  <= a_lo;
    operand_a_high <= a_hi;
    operand_b_low  <= b_lo;
    operand_b_high <= b_hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [2:0]  op;
    logic [1:0]  wsel;
    logic [10:0] addr;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
    int          pick;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: cleared store, wrap of sums, halves of a word, carry across halves
    send_request(K_READ, W_64, 11'd0, '0, '0, '0, '0);
    send_request(K_SWAP, W_64, 11'd2047, ONES, ONES, ONES, ONES);
    send_request(K_FETCH_ADD, W_64, 11'd2047, 64'd1, '0, '0, '0);
    send_request(K_SWAP, W_32, 11'd6, 64'hFFFF_FFFF_DEAD_BEEF, '0, '0, '0);
    send_request(K_SWAP, W_32, 11'd7, ONES, '0, '0, '0);
    send_request(K_FETCH_ADD, W_32, 11'd7, 64'hABCD_0000_0000_0001, '0, '0, '0);
    send_request(K_READ, W_64, 11'd6, '0, '0, '0, '0);
    send_request(K_SWAP, W_128, 11'd9, ONES, '0, '0, '0);
    send_request(K_FETCH_ADD, W_128, 11'd8, 64'd1, '0, '0, '0);
    send_request(K_READ, W_128, 11'd11, '0, '0, '0, '0);
    // compare hits on {1, 0}, then misses on the same operand
    send_request(K_COMPARE_STORE, W_128, 11'd8, '0, 64'd1, 64'h5555_AAAA_5555_AAAA, ONES);
    send_request(K_COMPARE_STORE, W_128, 11'd8, '0, 64'd1, ONES, ONES);
    send_request(K_COMPARE_STORE, W_64, 11'd20, '0, '0, 64'h1234_5678_9ABC_DEF0, '0);
    send_request(K_COMPARE_STORE, W_32, 11'd21, 64'd5, '0, ONES, '0);
    send_request(K_COMPARE_STORE, W_32, 11'd20, 64'hFFFF_FFFF_9ABC_DEF0, '0, 64'd3, '0);
    send_request(K_FETCH_AND, W_64, 11'd20, 64'hF0F0_F0F0_F0F0_F0F0, '0, '0, '0);
    send_request(K_FETCH_OR, W_32, 11'd21, 64'h8000_0001, '0, '0, '0);
    send_request(K_FETCH_XOR, W_128, 11'd8, ONES, ONES, '0, '0);
    send_request(K_UNDEFINED, W_64, 11'd20, ONES, ONES, ONES, ONES);
    // width code 3 behaves as 128-bit, at the top pair of the store
    send_request(K_SWAP, W_128_ALIAS, 11'd2047, 64'hCAFE_F00D_0000_0001, ONES, '0, '0);
    send_request(K_FETCH_ADD, W_128_ALIAS, 11'd2044, ONES, ONES, '0, '0);
    send_request(K_UNDEFINED, W_128_ALIAS, 11'd2045, ONES, ONES, ONES, ONES);
    send_request(K_FETCH_AND, W_128, 11'd2044, 64'h0000_FFFF_0000_FFFF, ONES, '0, '0);
    send_request(K_FETCH_OR, W_128, 11'd8, ONES, '0, '0, '0);
    send_request(K_FETCH_XOR, W_64, 11'd2046, 64'hA5A5_A5A5_A5A5_A5A5, '0, '0, '0);

    // random: three idling phases, hot address window and shared operand pairs
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 26;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op   = 3'($urandom_range(0, 7));
      wsel = 2'($urandom_range(0, 3));
      addr = 11'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                             : $urandom_range(0, 2047));
      if ($urandom_range(0, 99) < 40) begin
        pick = $urandom_range(0, 3);
        a_lo = pool_low[pick];
        a_hi = pool_high[pick];
        pick = $urandom_range(0, 3);
        b_lo = pool_low[pick];
        b_hi = pool_high[pick];
      end else begin
        a_lo = random_word();
        a_hi = random_word();
        b_lo = random_word();
        b_hi = random_word();
      end
      send_request(op, wsel, addr, a_lo, a_hi, b_lo, b_hi);
    end
    in_valid <= 1'b0;

    // drain the outstanding results, then a few quiet cycles
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[atomic_memory_op_unit] OK");
    end else begin
      $display("[atomic_memory_op_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/amou_pkg.sv
hw/rtl/amou_ram.sv
hw/rtl/amou_alu.sv
hw/rtl/atomic_memory_op_unit.sv
hw/rtl/amou_checker.sv
tb/sv/amou_checker.sv
tb/sv/tb_top.sv
